>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define KSIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// when ante holds, cons must hold in the following cycle
`define KSIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ksir_pkg.sv
// ----------------------------------------------------------------------------
// ksir_pkg
// Shared types and constants of the keyed stack with insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

package ksir_pkg;

  localparam int DEPTH   = 8;
  localparam int KEY_W   = 56;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_W   = 4;
  localparam int MOV_W   = 3;
  localparam int OCC_W   = 4;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);
  localparam logic             REG_CAPACITY = 1'b0;  // register index (paddr[2])

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // per-cell update controls
  typedef struct packed {
    logic load;      // take the incoming key (push lands here)
    logic shift_en;  // removal: cells at or above the hit take the upper key
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/ksir_cell.sv
// ----------------------------------------------------------------------------
// ksir_cell
// One stack slot: holds a key, compares it with the broadcast key and passes
// the hit chain upward; on removal it takes the key of the slot above.
// ----------------------------------------------------------------------------
`default_nettype none

module ksir_cell (
  input  logic                      clk_i,
  input  logic [ksir_pkg::KEY_W-1:0] key_i,     // broadcast key
  input  logic [ksir_pkg::KEY_W-1:0] up_key_i,  // key of the slot above
  input  logic                      occ_i,     // slot holds a live key
  input  logic                      hit_i,     // a match lies below
  input  ksir_pkg::cell_ctl_t       ctl_i,
  output logic                      hit_o,
  output logic                      match_o,
  output logic [ksir_pkg::KEY_W-1:0] key_o
);
  import ksir_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;

  assign match_o = occ_i && (key_q == key_i);
  assign hit_o   = hit_i | match_o;
  assign key_o   = key_q;

  always_comb begin
    key_d = key_q;
    if (ctl_i.shift_en && hit_o) begin
      key_d = up_key_i;
    end else if (ctl_i.load) begin
      key_d = key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

>>> sv/keyed_stack_insert_remove.sv
// ----------------------------------------------------------------------------
// keyed_stack_insert_remove
// Bounded stack of 56-bit keys with duplicate check, push and remove-by-key.
// ----------------------------------------------------------------------------
// Usage:
//   Input words on s_axis: tuser carries the op (0 insert, 1 remove), tdata
//   the key. Each word yields exactly one result word on m_axis: tuser holds
//   the status, tdata holds moves and the occupancy after the operation.
//   The capacity register sits at APB address 0 (reset 5, limited to 8).
//   An accepted word is executed in the S_EXEC state by the row of eight
//   slot cells: all slots compare in parallel, the hit ripples up the chain,
//   and on a removal every slot at or above the hit takes its upper neighbor's key.
//   The result is registered; no new word is taken until the current one has
//   executed, bounded by the accept/execute pair of the controller.
//   The result register lets the next word be accepted while a result waits;
//   if the receiver stalls, execution of that word holds until the result
//   register frees up. Reset empties the stack and restores the capacity.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module keyed_stack_insert_remove (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ksir_pkg::KEY_W-1:0]    s_axis_tdata,   // [55:0] plate
  input  logic                          s_axis_tuser,   // [0] op
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [2:0] moves, [6:3] occupancy, [7] 0
  output logic [2:0]                    m_axis_tuser,   // [2:0] status
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ksir_pkg::APB_AW-1:0]   paddr,
  input  logic [ksir_pkg::APB_DW-1:0]   pwdata,
  output logic [ksir_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import ksir_pkg::*;

  state_e              state_q, state_d;
  op_e                 op_q;
  logic [KEY_W-1:0]    key_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CAP_W-1:0]    cap_q;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, status_d;
  logic [MOV_W-1:0]    out_moves_q, moves_d;
  logic [OCC_W-1:0]    out_occ_q;

  logic                accept, exec_go, cfg_wr;
  logic [DEPTH-1:0]    occ_vec, match_vec, above_vec;
  logic [DEPTH:0]      hit_chain;
  logic [KEY_W-1:0]    cell_key [DEPTH];
  cell_ctl_t           cell_ctl [DEPTH];
  logic                dup, rem_found, ins_ok;
  logic [CNT_W-1:0]    limit, above_cnt;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign limit = (CNT_W'(cap_q) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_q);

  // ---------------- control ----------------
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_EXEC;
      S_EXEC: if (exec_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_EXEC:  s_axis_tready = 1'b0;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(s_axis_tuser);
      key_q <= s_axis_tdata;
    end
  end

  // ---------------- cell row ----------------
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] up_key;

    assign occ_vec[i]   = CNT_W'(i) < count_q;
    assign above_vec[i] = hit_chain[i];
    assign cell_ctl[i].load     = exec_go && ins_ok && (CNT_W'(i) == count_q);
    assign cell_ctl[i].shift_en = exec_go && rem_found;

    if (i < DEPTH - 1) begin : g_mid
      assign up_key = cell_key[i+1];
    end else begin : g_top
      assign up_key = '0;  // top slot empties on removal
    end

    ksir_cell u_cell (
      .clk_i    (clk_i),
      .key_i    (key_q),
      .up_key_i (up_key),
      .occ_i    (occ_vec[i]),
      .hit_i    (hit_chain[i]),
      .ctl_i    (cell_ctl[i]),
      .hit_o    (hit_chain[i+1]),
      .match_o  (match_vec[i]),
      .key_o    (cell_key[i])
    );
  end

  // keys are unique, so at most one slot matches
  assign dup       = |match_vec;
  assign rem_found = (op_q == OP_REMOVE) && dup;
  assign ins_ok    = (op_q == OP_INSERT) && !dup && (count_q < limit);

  always_comb begin
    above_cnt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      above_cnt = above_cnt + CNT_W'(above_vec[i] && occ_vec[i]);
    end
  end

  always_comb begin
    count_d  = count_q;
    moves_d  = '0;
    status_d = ST_NOT_FOUND;
    unique case (op_q)
      OP_INSERT: begin
        if (dup) begin
          status_d = ST_PRESENT;
        end else if (!ins_ok) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_INSERTED;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (rem_found) begin
          status_d = ST_REMOVED;
          count_d  = count_q - CNT_W'(1);
          moves_d  = (above_cnt > CNT_W'((1 << MOV_W) - 1)) ? '1 : above_cnt[MOV_W-1:0];
        end
      end
      default: status_d = ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (exec_go) begin
      count_q <= count_d;
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_status_q <= status_d;
      out_moves_q  <= moves_d;
      out_occ_q    <= OCC_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_occ_q, out_moves_q};

  // ---------------- assertions ----------------
  `KSIR_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "count beyond depth")
  `KSIR_ASSERT(a_unique_keys, $onehot0(match_vec), "duplicate key held in stack")
  `KSIR_ASSERT_NEXT(a_exec_result, exec_go, out_valid_q, "executed word gave no result")
  `KSIR_ASSERT_NEXT(a_count_hold, !exec_go, $stable(count_q), "count moved without execution")
  `KSIR_ASSERT_NEXT(a_remove_dec, exec_go && rem_found,
                    count_q == $past(count_q) - CNT_W'(1), "removal did not shrink stack")

endmodule

`default_nettype wire

>>> tb/sv/keyed_stack_insert_remove_test.sv
// ----------------------------------------------------------------------------
// keyed_stack_insert_remove_test
// Drives insert and remove words into the keyed stack while the capacity is
// moved through its whole range, keeps a shadow copy of the stack, and checks
// each result word's status, moves and occupancy against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyed_stack_insert_remove_test;
  import ksir_pkg::*;

  // ~850 words plus drains; the limit covers them many times over
  localparam int CYCLE_LIMIT = 500_000;
  localparam logic [APB_AW-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  typedef struct {
    status_e           status;
    logic [MOV_W-1:0]  moves;
    logic [OCC_W-1:0]  occupancy;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [KEY_W-1:0]    s_axis_tdata = '0;    // [55:0] plate
  logic                s_axis_tuser = 1'b0;  // [0] op
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;         // [2:0] moves, [6:3] occupancy
  logic [2:0]          m_axis_tuser;         // [2:0] status
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // shadow state: index 0 is the bottom of the stack
  logic [KEY_W-1:0]    held_keys[$];
  logic [CAP_W-1:0]    cap_reg = CAP_RESET;
  outcome_t            pending[$];

  int idle_pct = 18;
  int errors = 0;
  int cycles = 0;
  int words_in = 0;
  int status_seen[5] = '{default: 0};
  int deepest_hit = 0;

  keyed_stack_insert_remove u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= idle_pct);
  end

  // updates the shadow stack for one word and returns its outcome
  function automatic outcome_t apply_word(op_e op, logic [KEY_W-1:0] plate);
    outcome_t o;
    int lim;
    int hit;
    o.moves = '0;
    lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    hit = -1;
    if (op == OP_INSERT) begin
      foreach (held_keys[i]) if (held_keys[i] == plate) hit = i;
      // a duplicate wins over a full stack
      if (hit >= 0) o.status = ST_PRESENT;
      else if (held_keys.size() >= lim) o.status = ST_FULL;
      else begin
        held_keys.push_back(plate);
        o.status = ST_INSERTED;
      end
    end else begin
      for (int i = held_keys.size() - 1; i >= 0 && hit < 0; i--)
        if (held_keys[i] == plate) hit = i;
      if (hit >= 0) begin
        o.moves = MOV_W'(held_keys.size() - 1 - hit);
        held_keys.delete(hit);
        o.status = ST_REMOVED;
      end else begin
        o.status = ST_NOT_FOUND;
      end
    end
    o.occupancy = OCC_W'(held_keys.size());
    return o;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    outcome_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
      $display("simulation failed");
      $finish;
    end
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending.push_back(apply_word(op_e'(s_axis_tuser), s_axis_tdata));
        words_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending.size() == 0) begin
          $error("result word with nothing outstanding: tuser %0d tdata 0x%02h",
                 m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          want = pending.pop_front();
          status_seen[want.status]++;
          if (want.status == ST_REMOVED && want.moves > deepest_hit) deepest_hit = want.moves;
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[2:0] !== want.moves) begin
            $error("moves: expected %0d, got %0d", want.moves, m_axis_tdata[2:0]);
            errors++;
          end
          if (m_axis_tdata[6:3] !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, m_axis_tdata[6:3]);
            errors++;
          end
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_word(op_e op, logic [KEY_W-1:0] plate);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = plate;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] value);
    wait_idle();
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = CAP_ADDR;
    pwdata  = APB_DW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_reg = value;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    // read back through prdata
    if (prdata !== APB_DW'(value)) begin
      $error("capacity: expected %0d, got %0d", value, prdata);
      errors++;
    end
  endtask

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [63:0] r;
    logic [KEY_W-1:0] k;
    r = {$urandom(), $urandom()};
    k = r[KEY_W-1:0];
    // zero bytes must still take part in the compare
    for (int b = 0; b < KEY_W / 8; b++) if ($urandom_range(7) == 0) k[8*b +: 8] = 8'h00;
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] held_key();
    return held_keys[$urandom_range(held_keys.size() - 1)];
  endfunction

  // one bit away from a held key, so a sloppy compare would hit
  function automatic logic [KEY_W-1:0] near_miss();
    logic [KEY_W-1:0] k;
    k = (held_keys.size() != 0) ? held_key() : fresh_key();
    k[$urandom_range(KEY_W - 1)] ^= 1'b1;
    return k;
  endfunction

  task automatic send_random_word();
    int unsigned r;
    r = $urandom_range(99);
    if (held_keys.size() != 0 && r < 35) send_word(OP_REMOVE, held_key());
    else if (r < 45) send_word(OP_REMOVE, near_miss());
    else if (held_keys.size() != 0 && r < 55) send_word(OP_INSERT, held_key());
    else if (r < 70) send_word(OP_INSERT, near_miss());
    else send_word(OP_INSERT, fresh_key());
  endtask

  localparam logic [KEY_W-1:0] KEY_ZERO = '0;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_ABC  = 56'h41_42_43_31_32_33_34;
  localparam logic [KEY_W-1:0] KEY_LOW  = 56'h00_00_00_00_00_00_01;
  localparam logic [KEY_W-1:0] KEY_HIGH = 56'h80_00_00_00_00_00_00;
  localparam logic [KEY_W-1:0] KEY_XYZ  = 56'h58_59_5A_39_38_37_36;

  // reset capacity of five: fill, overflow, duplicate on a full stack
  task automatic test_default_capacity();
    send_word(OP_INSERT, KEY_ZERO);
    send_word(OP_INSERT, KEY_ONES);
    send_word(OP_INSERT, KEY_ABC);
    send_word(OP_INSERT, KEY_LOW);
    send_word(OP_INSERT, KEY_HIGH);
    send_word(OP_INSERT, KEY_XYZ);
    send_word(OP_INSERT, KEY_ONES);
  endtask

  task automatic test_remove_search();
    send_word(OP_REMOVE, KEY_ABC);   // middle, two above
    send_word(OP_REMOVE, KEY_XYZ);   // absent
    send_word(OP_REMOVE, KEY_HIGH);  // top
    send_word(OP_INSERT, KEY_ABC);
  endtask

  task automatic test_capacity_extremes();
    set_capacity(4'd15);             // limit saturates at DEPTH
    send_word(OP_INSERT, KEY_XYZ);
    send_word(OP_INSERT, KEY_HIGH);
    send_word(OP_INSERT, 56'h01);
    send_word(OP_INSERT, 56'h7F_FF_FF_FF_FF_FF_FF);
    send_word(OP_INSERT, 56'h12_34_56_78_9A_BC_DE);
    set_capacity(4'd2);              // below the current count
    send_word(OP_INSERT, 56'h12_34_56_78_9A_BC_DE);
    send_word(OP_REMOVE, KEY_ZERO);  // bottom of a full stack
    set_capacity(4'd0);
    send_word(OP_INSERT, 56'h00_00_00_00_00_01_00);
    send_word(OP_INSERT, KEY_ONES);
  endtask

  task automatic test_random_phases();
    logic [CAP_W-1:0] caps[10] = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd0, 4'd6, 4'd2, 4'd5, 4'd4,
                                   4'd7};
    for (int p = 0; p < 10; p++) begin
      set_capacity(caps[p]);
      repeat ((caps[p] == 0) ? 30 : 80) send_random_word();
    end
  endtask

  // back to back on both sides
  task automatic test_no_idle_burst();
    set_capacity(4'd8);
    idle_pct = 0;
    repeat (100) send_random_word();
    wait_idle();
    idle_pct = 18;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_capacity();
    test_remove_search();
    test_capacity_extremes();
    test_random_phases();
    test_no_idle_burst();
    wait_idle();

    $display("%0d words over capacities 0 to 15: %0d inserted, %0d duplicate, %0d full",
             words_in, status_seen[ST_INSERTED], status_seen[ST_PRESENT],
             status_seen[ST_FULL]);
    $display("%0d removed (up to %0d entries above the hit), %0d not found, %0d errors",
             status_seen[ST_REMOVED], deepest_hit, status_seen[ST_NOT_FOUND], errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/ksir_pkg.sv
sv/ksir_cell.sv
sv/keyed_stack_insert_remove.sv
tb/sv/keyed_stack_insert_remove_test.sv
